// ===== hw/rtl/hpq_pkg.sv =====
// shared types, constants and the key ordering function of the heap priority queue
`default_nettype none

package hpq_pkg;

  // default heap capacity in entries
  localparam int CAPACITY_DEF = 1024;

  // fixed field widths
  localparam int KEY_W  = 32;
  localparam int FUNC_W = 2;
  localparam int FILL_W = 11;
  localparam int ERR_W  = 2;

  // operation codes, code 3 acts as a query
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_PUSH_FULL = 2'd2;

  // true when key a belongs above key b under the selected order
  function automatic logic beats(input logic signed [KEY_W-1:0] a,
                                 input logic signed [KEY_W-1:0] b,
                                 input logic                    order_min);
    return order_min ? (a < b) : (a > b);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hpq_ram.sv =====
// generic synchronous ram, one write port and two registered read ports
`default_nettype none

module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/binary_heap_priority_queue_unit.sv =====
// top level of the binary heap priority queue
`default_nettype none

// Binary heap priority queue of signed 32-bit keys, max-heap or min-heap as
// chosen by order_min. Each input transaction pushes a key, pops the top or
// only queries; each gives one result with the top after the operation, its
// valid flag, the fill count and an error code. Items are handled one at a
// time. A query or a rejected operation goes straight to the result. A push
// places the key at the new last slot and moves it up one level at a time
// while it beats its parent; a pop moves the last entry to the root and moves
// it down one level at a time while a child beats it, and a pop that empties
// the queue moves nothing. Each level is one pass of the read-compare-write
// loop on the key memory, reading the parent or both children and writing
// the hole back. A result waits to enter the output register while that
// register still holds an unaccepted one. The next transaction is taken while
// a finished result waits in the output register. Changing order_min while
// entries are held does not reorder them. The key memory needs no clearing
// after reset.
module binary_heap_priority_queue_unit
  import hpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic                    cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [FUNC_W-1:0]       func,
  input  wire logic signed [KEY_W-1:0] value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [KEY_W-1:0]      top_value,
  output logic                         top_valid,
  output logic [FILL_W-1:0]            fill_count,
  output logic [ERR_W-1:0]             error
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t                   state;
  logic                     order_min;
  logic [CW-1:0]            count;
  logic [CW-1:0]            hole;
  logic signed [KEY_W-1:0]  key;
  logic signed [KEY_W-1:0]  top_key;
  logic [ERR_W-1:0]         err;

  logic                     accept;
  logic [CW:0]              l_slot;
  logic [CW:0]              r_slot;
  logic [CW-1:0]            p_slot;
  logic                     l_ok;
  logic                     r_ok;
  logic                     lwin;
  logic                     rwin;
  logic                     upwin;
  logic signed [KEY_W-1:0]  lbest;
  logic signed [KEY_W-1:0]  rd_a;
  logic signed [KEY_W-1:0]  rd_b;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [KEY_W-1:0]         mem_wdata;
  logic [AW-1:0]            mem_raddr_a;
  logic [AW-1:0]            mem_raddr_b;
  logic [KEY_W-1:0]         mem_rdata_a;
  logic [KEY_W-1:0]         mem_rdata_b;

  // key store
  hpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .rdata_a (mem_rdata_a),
    .raddr_b (mem_raddr_b),
    .rdata_b (mem_rdata_b)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_a     = mem_rdata_a;
  assign rd_b     = mem_rdata_b;

  // heap slot arithmetic around the hole
  assign l_slot = {hole, 1'b0};
  assign r_slot = {hole, 1'b1};
  assign p_slot = hole >> 1;
  assign l_ok   = l_slot <= {1'b0, count};
  assign r_ok   = r_slot <= {1'b0, count};

  // comparisons for one level of sift down and sift up
  assign lwin  = beats(rd_a, key, order_min);
  assign lbest = lwin ? rd_a : key;
  assign rwin  = r_ok && beats(rd_b, lbest, order_min);
  assign upwin = beats(key, rd_a, order_min);

  // memory port control
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = AW'(hole - CW'(1));
    mem_wdata   = key;
    mem_raddr_a = AW'(l_slot - (CW + 1)'(1));
    mem_raddr_b = AW'(r_slot - (CW + 1)'(1));
    case (state)
      S_IDLE: begin
        // last entry, used by a pop
        mem_raddr_a = AW'(count - CW'(1));
      end
      S_UP_RD: begin
        mem_raddr_a = AW'(p_slot - CW'(1));
        mem_we      = (hole == CW'(1));
      end
      S_UP_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = upwin ? rd_a : key;
      end
      S_DN_RD: begin
        mem_we = !l_ok;
      end
      S_DN_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = rwin ? rd_b : (lwin ? rd_a : key);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // sequencer, count, root copy and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      order_min <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        order_min <= cfg_data;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      // keep a copy of the root for the result
      if (mem_we && hole == CW'(1)) begin
        top_key <= mem_wdata;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            err <= ERR_NONE;
            key <= value;
            if (func == FUNC_PUSH) begin
              if (count >= CW'(CAPACITY)) begin
                err   <= ERR_PUSH_FULL;
                state <= S_DONE;
              end else begin
                count <= count + CW'(1);
                hole  <= count + CW'(1);
                state <= S_UP_RD;
              end
            end else if (func == FUNC_POP) begin
              if (count == '0) begin
                err   <= ERR_POP_EMPTY;
                state <= S_DONE;
              end else begin
                count <= count - CW'(1);
                state <= S_POP_RD;
              end
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_POP_RD: begin
          if (count == '0) begin
            state <= S_DONE;
          end else begin
            key   <= rd_a;
            hole  <= CW'(1);
            state <= S_DN_RD;
          end
        end
        S_UP_RD: begin
          state <= (hole == CW'(1)) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (upwin) begin
            hole  <= p_slot;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_RD: begin
          state <= l_ok ? S_DN_CMP : S_DONE;
        end
        S_DN_CMP: begin
          if (rwin) begin
            hole  <= CW'(r_slot);
            state <= S_DN_RD;
          end else if (lwin) begin
            hole  <= CW'(l_slot);
            state <= S_DN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            top_value  <= (count != '0) ? top_key : '0;
            top_valid  <= (count != '0);
            fill_count <= FILL_W'(count);
            error      <= err;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hpq_checker.sv =====
// port-level checker of the heap priority queue and its bind
`default_nettype none

module hpq_checker
  import hpq_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [KEY_W-1:0] top_value,
  input wire logic                    top_valid,
  input wire logic [FILL_W-1:0]       fill_count,
  input wire logic [ERR_W-1:0]        error
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(error)
      && $stable(fill_count))
    else $error("result changed while stalled");

  // an empty queue reports no entries and a zero top
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !top_valid |-> fill_count == '0 && top_value == '0)
    else $error("empty queue reports entries or a top");

  // a pop error only happens on an empty queue
  a_pop_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error == ERR_POP_EMPTY |-> !top_valid)
    else $error("pop error on a non-empty queue");

  // a full-queue error leaves a valid top
  a_push_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error == ERR_PUSH_FULL |-> top_valid)
    else $error("push error on a queue without entries");

  // each transaction is worked on alone
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in work");

endmodule

bind binary_heap_priority_queue_unit hpq_checker u_hpq_checker (.*);

`default_nettype wire
